>>> design/line_segment_intersection_defines.svh
// assertion macros shared by the line segment intersection rtl
// expects a clock named clock and an active high reset named reset in scope
`ifndef LINE_SEGMENT_INTERSECTION_DEFINES_SVH
`define LINE_SEGMENT_INTERSECTION_DEFINES_SVH

// same cycle implication
`define LSI_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsi assertion failed");

// next cycle implication
`define LSI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsi assertion failed");

`endif

>>> design/lsi_pkg.sv
// package for the line segment intersection block: widths, types, register codes
// no dependencies
`timescale 1ns / 1ps

package lsi_pkg;

   localparam int COORD_W  = 32;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int CROSS_W  = PROD_W;
   localparam int TOL_W    = 16;
   localparam int EPS_W    = 32;
   localparam int LOWB_W   = CROSS_W + TOL_W;
   localparam int SCALED_W = LOWB_W + 1;
   localparam int SPLIT_W  = COORD_W;
   localparam int HI_W     = CROSS_W - SPLIT_W;
   localparam int MAG_W    = CROSS_W + COORD_W;
   localparam int NUM_W    = MAG_W + 2;
   localparam int DDEN_W   = CROSS_W + 1;
   localparam int QB       = COORD_W + 2;
   localparam int CMP_W    = DDEN_W + QB;
   localparam int SUM_W    = QB + 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEGMENT_TOLERANCE = 2'd0,
      CSR_PARALLEL_EPSILON  = 2'd1
   } csr_index_type;

   // classified item handed from front to back
   typedef struct packed {
      logic                       found;
      logic signed [COORD_W-1:0]  x1;
      logic signed [COORD_W-1:0]  y1;
      logic signed [DIFF_W-1:0]   dx;
      logic signed [DIFF_W-1:0]   dy;
      logic signed [CROSS_W-1:0]  ns;
      logic        [CROSS_W-1:0]  den;
   } mid_item_type;

   // result beat
   typedef struct packed {
      logic                       found;
      logic signed [COORD_W-1:0]  hit_x;
      logic signed [COORD_W-1:0]  hit_y;
      logic                       saturated;
   } rsp_item_type;

   // sideband that rides along one divider lane
   typedef struct packed {
      logic                       found;
      logic                       neg;
      logic signed [COORD_W-1:0]  base;
   } div_side_type;

   function automatic logic signed [DIFF_W-1:0] coord_diff(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
   endfunction

endpackage

>>> design/line_segment_intersection.sv
// top level of the line / segment intersection block: csr registers, queues, front and back
// depends on lsi_pkg, lsi_fifo, lsi_front, lsi_back and line_segment_intersection_defines.svh
`timescale 1ns / 1ps
`include "line_segment_intersection_defines.svh"

// Intersection of two lines p1-p2 and p3-p4 given in signed Q16.16. Items enter as beats on a
// push/full queue port and results leave on an empty/pop queue port, one result per item, in
// order. The block takes one beat per clock cycle for as long as results are popped. An item
// passes six stages in the front (differences, six 33x33 products, cross products, sign fold,
// tolerance product, bound), the middle queue, four product/rounding stages, the 34 bit
// quotient pipeline with one stage per bit plus its overflow check, and one sum stage before
// the result queue. Segment mode (mode 0) reports a hit only for tol < s,t < 1 - tol with a
// nonzero determinant; line mode (mode 1) reports one whenever |det| exceeds parallel_epsilon.
// Points are rounded to nearest, ties away from zero, and clipped to the Q16.16 range with
// saturated set. Registers are to be written through csr_wr_en / csr_index / csr_wdata only
// while no beat is in flight; the block itself does not enforce this.

module line_segment_intersection #(
   parameter int QUEUE_DEPTH = lsi_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input queue port
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_mode,
   input  logic signed [lsi_pkg::COORD_W-1:0]    req_p1_x,
   input  logic signed [lsi_pkg::COORD_W-1:0]    req_p1_y,
   input  logic signed [lsi_pkg::COORD_W-1:0]    req_p2_x,
   input  logic signed [lsi_pkg::COORD_W-1:0]    req_p2_y,
   input  logic signed [lsi_pkg::COORD_W-1:0]    req_p3_x,
   input  logic signed [lsi_pkg::COORD_W-1:0]    req_p3_y,
   input  logic signed [lsi_pkg::COORD_W-1:0]    req_p4_x,
   input  logic signed [lsi_pkg::COORD_W-1:0]    req_p4_y,
   // result queue port
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic                                  rsp_found,
   output logic signed [lsi_pkg::COORD_W-1:0]    rsp_hit_x,
   output logic signed [lsi_pkg::COORD_W-1:0]    rsp_hit_y,
   output logic                                  rsp_saturated,
   // register write port
   input  logic                                  csr_wr_en,
   input  logic        [lsi_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [lsi_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int MID_W = $bits(lsi_pkg::mid_item_type);
   localparam int RSP_W = $bits(lsi_pkg::rsp_item_type);

   // configuration registers
   logic [lsi_pkg::TOL_W-1:0] tol_ff, tol_in;
   logic [lsi_pkg::EPS_W-1:0] eps_ff, eps_in;

   // front to middle queue
   logic                  accept;
   logic                  front_valid;
   lsi_pkg::mid_item_type front_item;
   logic                  mid_full, mid_empty, mid_pop;
   lsi_pkg::mid_item_type mid_item;

   // back to result queue
   logic                  back_enable;
   logic                  back_valid;
   lsi_pkg::rsp_item_type back_item;
   logic                  out_full, out_pop;
   lsi_pkg::rsp_item_type out_item;

   // register writes, unknown indexes are dropped
   always_comb begin
      tol_in = tol_ff;
      eps_in = eps_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lsi_pkg::CSR_SEGMENT_TOLERANCE: tol_in = csr_wdata[lsi_pkg::TOL_W-1:0];
            lsi_pkg::CSR_PARALLEL_EPSILON:  eps_in = csr_wdata[lsi_pkg::EPS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
         eps_ff <= '0;
      end else begin
         tol_ff <= tol_in;
         eps_ff <= eps_in;
      end
   end

   // the front pipeline runs while the middle queue has room
   assign req_full = mid_full;
   assign accept   = req_push && !mid_full;

   lsi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (!mid_full),
      .in_valid (accept),
      .in_mode  (req_mode),
      .in_p1_x  (req_p1_x),
      .in_p1_y  (req_p1_y),
      .in_p2_x  (req_p2_x),
      .in_p2_y  (req_p2_y),
      .in_p3_x  (req_p3_x),
      .in_p3_y  (req_p3_y),
      .in_p4_x  (req_p4_x),
      .in_p4_y  (req_p4_y),
      .tol      (tol_ff),
      .eps      (eps_ff),
      .out_valid(front_valid),
      .out_item (front_item)
   );

   // decouples classification from the long divide pipeline
   lsi_fifo #(.WIDTH(MID_W), .DEPTH(QUEUE_DEPTH)) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_data (front_item),
      .rd_en   (mid_pop),
      .rd_data (mid_item),
      .full    (mid_full),
      .empty   (mid_empty)
   );

   // the back pipeline runs while the result queue has room
   assign back_enable = !out_full;
   assign mid_pop     = back_enable && !mid_empty;

   lsi_back u_back (
      .clock    (clock),
      .reset    (reset),
      .enable   (back_enable),
      .in_valid (mid_pop),
      .in_item  (mid_item),
      .out_valid(back_valid),
      .out_item (back_item)
   );

   lsi_fifo #(.WIDTH(RSP_W), .DEPTH(QUEUE_DEPTH)) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (back_valid),
      .wr_data (back_item),
      .rd_en   (out_pop),
      .rd_data (out_item),
      .full    (out_full),
      .empty   (rsp_empty)
   );

   assign out_pop       = rsp_pop && !rsp_empty;
   assign rsp_found     = out_item.found;
   assign rsp_hit_x     = out_item.hit_x;
   assign rsp_hit_y     = out_item.hit_y;
   assign rsp_saturated = out_item.saturated;

   // a miss beat carries a clean zero point
   `LSI_ASSERT_IMP(a_miss_is_zero, !rsp_empty && !rsp_found, rsp_hit_x == '0 && rsp_hit_y == '0 && !rsp_saturated)

endmodule

>>> design/lsi_fifo.sv
// small register queue used between front and back and on the result side
// depends on line_segment_intersection_defines.svh
`timescale 1ns / 1ps
`include "line_segment_intersection_defines.svh"

module lsi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);

   `LSI_ASSERT_IMP(a_fifo_no_overflow, wr_en && !rd_en, !full)
   `LSI_ASSERT_NEXT(a_fifo_push_lands, wr_en && !rd_en, !empty)

endmodule

>>> design/lsi_front.sv
// front part: differences, cross products, sign normalization and hit classification
// depends on lsi_pkg
`timescale 1ns / 1ps

module lsi_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  logic                                 in_valid,
   input  logic                                 in_mode,
   input  logic signed [lsi_pkg::COORD_W-1:0]   in_p1_x,
   input  logic signed [lsi_pkg::COORD_W-1:0]   in_p1_y,
   input  logic signed [lsi_pkg::COORD_W-1:0]   in_p2_x,
   input  logic signed [lsi_pkg::COORD_W-1:0]   in_p2_y,
   input  logic signed [lsi_pkg::COORD_W-1:0]   in_p3_x,
   input  logic signed [lsi_pkg::COORD_W-1:0]   in_p3_y,
   input  logic signed [lsi_pkg::COORD_W-1:0]   in_p4_x,
   input  logic signed [lsi_pkg::COORD_W-1:0]   in_p4_y,
   input  logic        [lsi_pkg::TOL_W-1:0]     tol,
   input  logic        [lsi_pkg::EPS_W-1:0]     eps,
   output logic                                 out_valid,
   output lsi_pkg::mid_item_type                out_item
);

   localparam int STAGES = 6;
   localparam int CW  = lsi_pkg::COORD_W;
   localparam int DW  = lsi_pkg::DIFF_W;
   localparam int PW  = lsi_pkg::PROD_W;
   localparam int XW  = lsi_pkg::CROSS_W;
   localparam int TW  = lsi_pkg::TOL_W;
   localparam int LW  = lsi_pkg::LOWB_W;
   localparam int SW  = lsi_pkg::SCALED_W;

   logic [STAGES-1:0] valid_ff;

   // stage 1: differences
   logic                 s1_mode_ff;
   logic signed [CW-1:0] s1_x1_ff, s1_y1_ff;
   logic signed [DW-1:0] s1_dx_ff, s1_dy_ff, s1_ex_ff, s1_ey_ff, s1_ax_ff, s1_ay_ff;
   // stage 2: products
   logic                 s2_mode_ff;
   logic signed [CW-1:0] s2_x1_ff, s2_y1_ff;
   logic signed [DW-1:0] s2_dx_ff, s2_dy_ff;
   logic signed [PW-1:0] s2_pd_a_ff, s2_pd_b_ff, s2_ps_a_ff, s2_ps_b_ff, s2_pt_a_ff, s2_pt_b_ff;
   // stage 3: cross products
   logic                 s3_mode_ff;
   logic signed [CW-1:0] s3_x1_ff, s3_y1_ff;
   logic signed [DW-1:0] s3_dx_ff, s3_dy_ff;
   logic signed [XW-1:0] s3_den_ff, s3_ns_ff, s3_nt_ff;
   // stage 4: positive determinant
   logic                 s4_mode_ff;
   logic signed [CW-1:0] s4_x1_ff, s4_y1_ff;
   logic signed [DW-1:0] s4_dx_ff, s4_dy_ff;
   logic        [XW-1:0] s4_den_ff;
   logic signed [XW-1:0] s4_ns_ff, s4_nt_ff;
   // stage 5: low bound
   logic                 s5_mode_ff;
   logic signed [CW-1:0] s5_x1_ff, s5_y1_ff;
   logic signed [DW-1:0] s5_dx_ff, s5_dy_ff;
   logic        [XW-1:0] s5_den_ff;
   logic signed [XW-1:0] s5_ns_ff, s5_nt_ff;
   logic        [LW-1:0] s5_lowb_ff;
   // stage 6: high bound
   logic                 s6_mode_ff;
   logic signed [CW-1:0] s6_x1_ff, s6_y1_ff;
   logic signed [DW-1:0] s6_dx_ff, s6_dy_ff;
   logic        [XW-1:0] s6_den_ff;
   logic signed [XW-1:0] s6_ns_ff, s6_nt_ff;
   logic        [LW-1:0] s6_lowb_ff, s6_highb_ff;

   logic                 den_neg;
   logic signed [SW-1:0] lowb_s, highb_s, s16, t16;
   logic                 seg_hit, line_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   assign den_neg = s3_den_ff[XW-1];

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_mode_ff <= in_mode;
         s1_x1_ff   <= in_p1_x;
         s1_y1_ff   <= in_p1_y;
         s1_dx_ff   <= lsi_pkg::coord_diff(in_p2_x, in_p1_x);
         s1_dy_ff   <= lsi_pkg::coord_diff(in_p2_y, in_p1_y);
         s1_ex_ff   <= lsi_pkg::coord_diff(in_p4_x, in_p3_x);
         s1_ey_ff   <= lsi_pkg::coord_diff(in_p4_y, in_p3_y);
         s1_ax_ff   <= lsi_pkg::coord_diff(in_p3_x, in_p1_x);
         s1_ay_ff   <= lsi_pkg::coord_diff(in_p3_y, in_p1_y);

         s2_mode_ff <= s1_mode_ff;
         s2_x1_ff   <= s1_x1_ff;
         s2_y1_ff   <= s1_y1_ff;
         s2_dx_ff   <= s1_dx_ff;
         s2_dy_ff   <= s1_dy_ff;
         s2_pd_a_ff <= PW'(s1_dx_ff) * PW'(s1_ey_ff);
         s2_pd_b_ff <= PW'(s1_dy_ff) * PW'(s1_ex_ff);
         s2_ps_a_ff <= PW'(s1_ax_ff) * PW'(s1_ey_ff);
         s2_ps_b_ff <= PW'(s1_ay_ff) * PW'(s1_ex_ff);
         s2_pt_a_ff <= PW'(s1_ax_ff) * PW'(s1_dy_ff);
         s2_pt_b_ff <= PW'(s1_ay_ff) * PW'(s1_dx_ff);

         s3_mode_ff <= s2_mode_ff;
         s3_x1_ff   <= s2_x1_ff;
         s3_y1_ff   <= s2_y1_ff;
         s3_dx_ff   <= s2_dx_ff;
         s3_dy_ff   <= s2_dy_ff;
         s3_den_ff  <= s2_pd_a_ff - s2_pd_b_ff;
         s3_ns_ff   <= s2_ps_a_ff - s2_ps_b_ff;
         s3_nt_ff   <= s2_pt_a_ff - s2_pt_b_ff;

         // flip all three so the determinant is never negative
         s4_mode_ff <= s3_mode_ff;
         s4_x1_ff   <= s3_x1_ff;
         s4_y1_ff   <= s3_y1_ff;
         s4_dx_ff   <= s3_dx_ff;
         s4_dy_ff   <= s3_dy_ff;
         s4_den_ff  <= den_neg ? XW'(-s3_den_ff) : XW'(s3_den_ff);
         s4_ns_ff   <= den_neg ? -s3_ns_ff : s3_ns_ff;
         s4_nt_ff   <= den_neg ? -s3_nt_ff : s3_nt_ff;

         s5_mode_ff <= s4_mode_ff;
         s5_x1_ff   <= s4_x1_ff;
         s5_y1_ff   <= s4_y1_ff;
         s5_dx_ff   <= s4_dx_ff;
         s5_dy_ff   <= s4_dy_ff;
         s5_den_ff  <= s4_den_ff;
         s5_ns_ff   <= s4_ns_ff;
         s5_nt_ff   <= s4_nt_ff;
         s5_lowb_ff <= LW'(s4_den_ff) * LW'(tol);

         s6_mode_ff  <= s5_mode_ff;
         s6_x1_ff    <= s5_x1_ff;
         s6_y1_ff    <= s5_y1_ff;
         s6_dx_ff    <= s5_dx_ff;
         s6_dy_ff    <= s5_dy_ff;
         s6_den_ff   <= s5_den_ff;
         s6_ns_ff    <= s5_ns_ff;
         s6_nt_ff    <= s5_nt_ff;
         s6_lowb_ff  <= s5_lowb_ff;
         s6_highb_ff <= {s5_den_ff, {TW{1'b0}}} - s5_lowb_ff;
      end
   end

   // s and t compared against the tolerance window, all scaled by det * 2^16
   always_comb begin
      lowb_s   = $signed({1'b0, s6_lowb_ff});
      highb_s  = $signed({1'b0, s6_highb_ff});
      s16      = $signed({s6_ns_ff[XW-1], s6_ns_ff, {TW{1'b0}}});
      t16      = $signed({s6_nt_ff[XW-1], s6_nt_ff, {TW{1'b0}}});
      seg_hit  = (s6_den_ff != '0) && (lowb_s < s16) && (s16 < highb_s)
               && (lowb_s < t16) && (t16 < highb_s);
      line_hit = s6_den_ff > XW'(eps);

      out_item.found = s6_mode_ff ? line_hit : seg_hit;
      out_item.x1    = s6_x1_ff;
      out_item.y1    = s6_y1_ff;
      out_item.dx    = s6_dx_ff;
      out_item.dy    = s6_dy_ff;
      out_item.ns    = s6_ns_ff;
      out_item.den   = s6_den_ff;
   end

   assign out_valid = valid_ff[STAGES-1] && enable;

endmodule

>>> design/lsi_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow detect
// depends on lsi_pkg
`timescale 1ns / 1ps

module lsi_div #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic [lsi_pkg::NUM_W-1:0]     in_num,
   input  logic [lsi_pkg::DDEN_W-1:0]    in_den,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic                          out_ovf,
   output logic [lsi_pkg::QB-1:0]        out_quo,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int QB  = lsi_pkg::QB;
   localparam int NW  = lsi_pkg::NUM_W;
   localparam int DW  = lsi_pkg::DDEN_W;
   localparam int CW  = lsi_pkg::CMP_W;

   logic [QB:0]        valid_ff;
   logic [NW-1:0]      rem_ff  [QB+1];
   logic [DW-1:0]      den_ff  [QB+1];
   logic [QB-1:0]      quo_ff  [QB+1];
   logic               ovf_ff  [QB+1];
   logic [SIDE_W-1:0]  side_ff [QB+1];

   logic [CW-1:0]      trial     [QB+1];
   logic               ge        [QB+1];
   logic [NW-1:0]      rem_next  [QB+1];
   logic [QB-1:0]      quo_next  [QB+1];

   // stage k decides quotient bit QB-k
   always_comb begin
      trial[0]    = '0;
      ge[0]       = 1'b0;
      rem_next[0] = '0;
      quo_next[0] = '0;
      for (int k = 1; k <= QB; k++) begin
         trial[k]    = CW'(den_ff[k-1]) << (QB - k);
         ge[k]       = CW'(rem_ff[k-1]) >= trial[k];
         rem_next[k] = ge[k] ? rem_ff[k-1] - trial[k][NW-1:0] : rem_ff[k-1];
         quo_next[k] = quo_ff[k-1] | (QB'(ge[k]) << (QB - k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[QB-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         quo_ff[0]  <= '0;
         ovf_ff[0]  <= CW'(in_num) >= (CW'(in_den) << QB);
         side_ff[0] <= in_side;
         for (int k = 1; k <= QB; k++) begin
            rem_ff[k]  <= rem_next[k];
            den_ff[k]  <= den_ff[k-1];
            quo_ff[k]  <= quo_next[k];
            ovf_ff[k]  <= ovf_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[QB];
   assign out_ovf   = ovf_ff[QB];
   assign out_quo   = quo_ff[QB];
   assign out_side  = side_ff[QB];

endmodule

>>> design/lsi_back.sv
// back part: s*d products, rounded division, offset from p1 and saturation
// depends on lsi_pkg, lsi_div and line_segment_intersection_defines.svh
`timescale 1ns / 1ps
`include "line_segment_intersection_defines.svh"

module lsi_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  lsi_pkg::mid_item_type  in_item,
   output logic                   out_valid,
   output lsi_pkg::rsp_item_type  out_item
);

   localparam int CW  = lsi_pkg::COORD_W;
   localparam int XW  = lsi_pkg::CROSS_W;
   localparam int SPW = lsi_pkg::SPLIT_W;
   localparam int HW  = lsi_pkg::HI_W;
   localparam int MW  = lsi_pkg::MAG_W;
   localparam int NW  = lsi_pkg::NUM_W;
   localparam int DDW = lsi_pkg::DDEN_W;
   localparam int QB  = lsi_pkg::QB;
   localparam int SUW = lsi_pkg::SUM_W;
   localparam int LOW = 2 * SPW;
   localparam int HIW = HW + SPW;
   localparam int SDW = $bits(lsi_pkg::div_side_type);

   logic [3:0] bv_ff;

   // b1: sign and magnitudes
   logic                 b1_found_ff, b1_negx_ff, b1_negy_ff;
   logic signed [CW-1:0] b1_x1_ff, b1_y1_ff;
   logic        [XW-1:0] b1_nsm_ff, b1_den_ff;
   logic        [CW-1:0] b1_dxm_ff, b1_dym_ff;
   // b2: partial products
   logic                 b2_found_ff, b2_negx_ff, b2_negy_ff;
   logic signed [CW-1:0] b2_x1_ff, b2_y1_ff;
   logic        [XW-1:0] b2_den_ff;
   logic        [LOW-1:0] b2_lox_ff, b2_loy_ff;
   logic        [HIW-1:0] b2_hix_ff, b2_hiy_ff;
   // b3: full products
   logic                 b3_found_ff, b3_negx_ff, b3_negy_ff;
   logic signed [CW-1:0] b3_x1_ff, b3_y1_ff;
   logic        [XW-1:0] b3_den_ff;
   logic        [MW-1:0] b3_magx_ff, b3_magy_ff;
   // b4: rounding numerator and doubled divisor
   logic                 b4_found_ff, b4_negx_ff, b4_negy_ff;
   logic signed [CW-1:0] b4_x1_ff, b4_y1_ff;
   logic        [NW-1:0] b4_numx_ff, b4_numy_ff;
   logic        [DDW-1:0] b4_dd_ff;

   logic                 ns_neg, dx_neg, dy_neg;
   logic        [XW-1:0] ns_mag;
   logic signed [lsi_pkg::DIFF_W-1:0] dx_abs, dy_abs;

   lsi_pkg::div_side_type side_x_in, side_y_in, side_x_out, side_y_out;
   logic            dvx, dvy, ovfx, ovfy;
   logic [QB-1:0]   quox, quoy;

   // e1: signed sum
   logic                  e1_valid_ff, e1_found_ff;
   logic                  e1_ovfx_ff, e1_ovfy_ff, e1_negx_ff, e1_negy_ff;
   logic signed [SUW-1:0] e1_sumx_ff, e1_sumy_ff;
   logic signed [SUW-1:0] qx_s, qy_s;

   logic [CW:0] clip_x, clip_y;

   function automatic logic [CW:0] clip_coord(
      input logic                  ovf,
      input logic                  neg,
      input logic signed [SUW-1:0] sum
   );
      logic signed [CW-1:0] v;
      logic                 sat;
      v   = sum[CW-1:0];
      sat = 1'b0;
      priority if (ovf) begin
         sat = 1'b1;
         v   = neg ? lsi_pkg::COORD_MIN : lsi_pkg::COORD_MAX;
      end else if (sum > SUW'(lsi_pkg::COORD_MAX)) begin
         sat = 1'b1;
         v   = lsi_pkg::COORD_MAX;
      end else if (sum < SUW'(lsi_pkg::COORD_MIN)) begin
         sat = 1'b1;
         v   = lsi_pkg::COORD_MIN;
      end
      return {sat, v};
   endfunction

   always_comb begin
      ns_neg = in_item.ns[XW-1];
      dx_neg = in_item.dx[lsi_pkg::DIFF_W-1];
      dy_neg = in_item.dy[lsi_pkg::DIFF_W-1];
      ns_mag = ns_neg ? XW'(-in_item.ns) : XW'(in_item.ns);
      dx_abs = dx_neg ? -in_item.dx : in_item.dx;
      dy_abs = dy_neg ? -in_item.dy : in_item.dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff       <= '0;
         e1_valid_ff <= 1'b0;
      end else if (enable) begin
         bv_ff       <= {bv_ff[2:0], in_valid};
         e1_valid_ff <= dvx;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         b1_found_ff <= in_item.found;
         b1_negx_ff  <= ns_neg ^ dx_neg;
         b1_negy_ff  <= ns_neg ^ dy_neg;
         b1_x1_ff    <= in_item.x1;
         b1_y1_ff    <= in_item.y1;
         b1_nsm_ff   <= ns_mag;
         b1_den_ff   <= in_item.den;
         b1_dxm_ff   <= dx_abs[CW-1:0];
         b1_dym_ff   <= dy_abs[CW-1:0];

         b2_found_ff <= b1_found_ff;
         b2_negx_ff  <= b1_negx_ff;
         b2_negy_ff  <= b1_negy_ff;
         b2_x1_ff    <= b1_x1_ff;
         b2_y1_ff    <= b1_y1_ff;
         b2_den_ff   <= b1_den_ff;
         b2_lox_ff   <= LOW'(b1_nsm_ff[SPW-1:0]) * LOW'(b1_dxm_ff);
         b2_loy_ff   <= LOW'(b1_nsm_ff[SPW-1:0]) * LOW'(b1_dym_ff);
         b2_hix_ff   <= HIW'(b1_nsm_ff[XW-1:SPW]) * HIW'(b1_dxm_ff);
         b2_hiy_ff   <= HIW'(b1_nsm_ff[XW-1:SPW]) * HIW'(b1_dym_ff);

         b3_found_ff <= b2_found_ff;
         b3_negx_ff  <= b2_negx_ff;
         b3_negy_ff  <= b2_negy_ff;
         b3_x1_ff    <= b2_x1_ff;
         b3_y1_ff    <= b2_y1_ff;
         b3_den_ff   <= b2_den_ff;
         b3_magx_ff  <= (MW'(b2_hix_ff) << SPW) + MW'(b2_lox_ff);
         b3_magy_ff  <= (MW'(b2_hiy_ff) << SPW) + MW'(b2_loy_ff);

         // round to nearest: (2|n| + d) / (2d)
         b4_found_ff <= b3_found_ff;
         b4_negx_ff  <= b3_negx_ff;
         b4_negy_ff  <= b3_negy_ff;
         b4_x1_ff    <= b3_x1_ff;
         b4_y1_ff    <= b3_y1_ff;
         b4_numx_ff  <= NW'({b3_magx_ff, 1'b0}) + NW'(b3_den_ff);
         b4_numy_ff  <= NW'({b3_magy_ff, 1'b0}) + NW'(b3_den_ff);
         b4_dd_ff    <= {b3_den_ff, 1'b0};
      end
   end

   always_comb begin
      side_x_in.found = b4_found_ff;
      side_x_in.neg   = b4_negx_ff;
      side_x_in.base  = b4_x1_ff;
      side_y_in.found = b4_found_ff;
      side_y_in.neg   = b4_negy_ff;
      side_y_in.base  = b4_y1_ff;
   end

   lsi_div #(.SIDE_W(SDW)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (bv_ff[3]),
      .in_num   (b4_numx_ff),
      .in_den   (b4_dd_ff),
      .in_side  (side_x_in),
      .out_valid(dvx),
      .out_ovf  (ovfx),
      .out_quo  (quox),
      .out_side (side_x_out)
   );

   lsi_div #(.SIDE_W(SDW)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (bv_ff[3]),
      .in_num   (b4_numy_ff),
      .in_den   (b4_dd_ff),
      .in_side  (side_y_in),
      .out_valid(dvy),
      .out_ovf  (ovfy),
      .out_quo  (quoy),
      .out_side (side_y_out)
   );

   always_comb begin
      qx_s = side_x_out.neg ? -$signed({2'b00, quox}) : $signed({2'b00, quox});
      qy_s = side_y_out.neg ? -$signed({2'b00, quoy}) : $signed({2'b00, quoy});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         e1_found_ff <= side_x_out.found;
         e1_ovfx_ff  <= ovfx;
         e1_ovfy_ff  <= ovfy;
         e1_negx_ff  <= side_x_out.neg;
         e1_negy_ff  <= side_y_out.neg;
         e1_sumx_ff  <= SUW'(side_x_out.base) + qx_s;
         e1_sumy_ff  <= SUW'(side_y_out.base) + qy_s;
      end
   end

   always_comb begin
      clip_x = clip_coord(e1_ovfx_ff, e1_negx_ff, e1_sumx_ff);
      clip_y = clip_coord(e1_ovfy_ff, e1_negy_ff, e1_sumy_ff);
      out_item.found     = e1_found_ff;
      out_item.hit_x     = e1_found_ff ? $signed(clip_x[CW-1:0]) : '0;
      out_item.hit_y     = e1_found_ff ? $signed(clip_y[CW-1:0]) : '0;
      out_item.saturated = e1_found_ff && (clip_x[CW] || clip_y[CW]);
   end

   assign out_valid = e1_valid_ff && enable;

   `LSI_ASSERT_IMP(a_div_lanes_aligned, 1'b1, dvx == dvy)

endmodule

>>> sim/tb_line_segment_intersection.sv
// self-checking testbench for line_segment_intersection: directed and random intersection queries
// depends on lsi_pkg and the line_segment_intersection rtl
`timescale 1ns / 1ps

module tb_line_segment_intersection;

   localparam int LATENCY   = 48;
   localparam int MAX_CYCLE = 400000;

   typedef struct {
      logic        mode;
      logic [31:0] c[8]; // p1x p1y p2x p2y p3x p3y p4x p4y
   } query_type;

   typedef struct {
      logic        found;
      logic [31:0] hx;
      logic [31:0] hy;
      logic        sat;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic req_mode = 1'b0;
   logic signed [31:0] req_c[8];
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic rsp_found, rsp_saturated;
   logic signed [31:0] rsp_hit_x, rsp_hit_y;
   logic csr_wr_en = 1'b0;
   logic [lsi_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lsi_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copies of the registers
   logic [15:0] tol_reg;
   logic [31:0] eps_reg;

   query_type pending_q[$];
   point_type expected_q[$];
   int     errors = 0;
   int     cycle = 0;

   // idling control
   bit calm = 1'b0;      // no idling at all
   bit hold_pop = 1'b0;  // long receiver hold-off
   int hold_cnt = 0;

   initial for (int i = 0; i < 8; i++) req_c[i] = '0;

   always #5 clock = ~clock;

   line_segment_intersection u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_mode(req_mode),
      .req_p1_x(req_c[0]), .req_p1_y(req_c[1]), .req_p2_x(req_c[2]), .req_p2_y(req_c[3]),
      .req_p3_x(req_c[4]), .req_p3_y(req_c[5]), .req_p4_x(req_c[6]), .req_p4_y(req_c[7]),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_found(rsp_found),
      .rsp_hit_x(rsp_hit_x), .rsp_hit_y(rsp_hit_y), .rsp_saturated(rsp_saturated),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // exact signed division, rounded to nearest with ties away from zero
   function automatic logic signed [191:0] div_round(input logic signed [191:0] num,
                                                     input logic signed [191:0] den);
      logic signed [191:0] nm, dm, q;
      nm = (num < 0) ? -num : num;
      dm = (den < 0) ? -den : den;
      q = (2 * nm + dm) / (2 * dm);
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   function automatic logic [31:0] clip(input logic signed [191:0] v, inout bit clipped);
      if (v > 192'sd2147483647) begin
         clipped = 1'b1;
         return 32'h7fffffff;
      end
      if (v < -192'sd2147483648) begin
         clipped = 1'b1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // expected intersection point for one query
   function automatic point_type predict_point(input query_type q);
      logic signed [191:0] x1, y1, dx, dy, ex, ey, ax, ay, det, ns, nt, lowb, highb, s16, t16;
      logic signed [191:0] t;
      bit hit, clipped;
      point_type r;
      x1 = $signed(q.c[0]);
      y1 = $signed(q.c[1]);
      dx = $signed(q.c[2]) - x1;
      dy = $signed(q.c[3]) - y1;
      ex = $signed(q.c[6]) - $signed(q.c[4]);
      ey = $signed(q.c[7]) - $signed(q.c[5]);
      ax = $signed(q.c[4]) - x1;
      ay = $signed(q.c[5]) - y1;
      det = dx * ey - dy * ex;
      ns = ax * ey - ay * ex;
      nt = ax * dy - ay * dx;
      if (q.mode == 1'b0) begin
         if (det < 0) begin
            det = -det;
            ns = -ns;
            nt = -nt;
         end
         t = tol_reg;
         lowb = det * t;
         highb = det * (65536 - t);
         s16 = ns * 65536;
         t16 = nt * 65536;
         hit = det != 0 && lowb < s16 && s16 < highb && lowb < t16 && t16 < highb;
      end else begin
         t = eps_reg;
         hit = ((det < 0) ? -det : det) > t;
      end
      r = '{1'b0, '0, '0, 1'b0};
      if (hit) begin
         clipped = 1'b0;
         r.found = 1'b1;
         r.hx = clip(x1 + div_round(ns * dx, det), clipped);
         r.hy = clip(y1 + div_round(ns * dy, det), clipped);
         r.sat = clipped;
      end
      return r;
   endfunction

   // input driver: push beats from the pending queue
   always @(posedge clock) begin
      bit accepted, idle;
      accepted = req_push && !req_full && !reset;
      if (accepted) begin
         query_type q;
         q = pending_q.pop_front();
         expected_q.push_back(predict_point(q));
      end
      if (req_push && !accepted) begin
         // keep offering the same beat
      end else begin
         idle = !calm && ($urandom_range(99) < 29);
         if (!reset && pending_q.size() > 0 && !idle) begin
            req_push <= 1'b1;
            req_mode <= pending_q[0].mode;
            for (int i = 0; i < 8; i++) req_c[i] <= pending_q[0].c[i];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // result monitor: compare every popped beat with the oldest expectation
   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result found=%0b x=%h y=%h", $time, rsp_found,
                     rsp_hit_x, rsp_hit_y);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_found !== e.found) begin
               $display("%0t: found expected %0b actual %0b", $time, e.found, rsp_found);
               errors++;
            end
            if (rsp_hit_x !== e.hx) begin
               $display("%0t: hit_x expected %h actual %h", $time, e.hx, rsp_hit_x);
               errors++;
            end
            if (rsp_hit_y !== e.hy) begin
               $display("%0t: hit_y expected %h actual %h", $time, e.hy, rsp_hit_y);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $display("%0t: saturated expected %0b actual %0b", $time, e.sat, rsp_saturated);
               errors++;
            end
         end
      end
      // receiver hold-off counted here
      if (hold_pop && hold_cnt < 200) begin
         hold_cnt <= hold_cnt + 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !reset && (calm || $urandom_range(99) >= 29);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord(input int kind);
      case (kind)
         0: return $urandom();
         1: return $signed($urandom_range(2000)) - 1000 <<< 16;   // small integers
         2: return $signed($urandom_range(131072)) - 65536;        // around zero
         default: return $signed($urandom_range(400000)) - 200000 <<< 8;
      endcase
   endfunction

   function automatic query_type rand_query();
      query_type q;
      int kind;
      kind = $urandom_range(3);
      q.mode = 1'($urandom_range(1));
      for (int i = 0; i < 8; i++) q.c[i] = rand_coord(kind);
      case ($urandom_range(9))
         0: begin // parallel: second line shifted copy of first
            q.c[6] = q.c[4] + (q.c[2] - q.c[0]);
            q.c[7] = q.c[5] + (q.c[3] - q.c[1]);
         end
         1: begin // nearly parallel
            q.c[6] = q.c[4] + (q.c[2] - q.c[0]) + $urandom_range(3);
            q.c[7] = q.c[5] + (q.c[3] - q.c[1]);
         end
         2: begin // endpoints touch: s or t exactly on the boundary
            q.c[4] = q.c[0];
            q.c[5] = q.c[1];
         end
         default: ;
      endcase
      return q;
   endfunction

   function automatic query_type make_query(input logic m, input logic [31:0] a, b, c, d,
                                            e, f, g, h);
      query_type q;
      q.mode = m;
      q.c = '{a, b, c, d, e, f, g, h};
      return q;
   endfunction

   task automatic write_reg(input lsi_pkg::csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == lsi_pkg::CSR_SEGMENT_TOLERANCE) tol_reg = val[15:0];
      else eps_reg = val;
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   initial begin
      logic [31:0] tols[5], epss[5];
      tol_reg = '0;
      eps_reg = '0;
      tols = '{16'd0, 16'd1, 16'd16384, 16'd32767, 16'd32768};
      epss = '{32'd0, 32'd1, 32'h10000, 32'h7fffffff, 32'hffffffff};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: crossing diagonals, parallel, touching, extremes, saturation
      calm = 1'b1;
      for (int m = 0; m < 2; m++) begin
         pending_q.push_back(make_query(1'(m), 0, 0, 32'h20000, 32'h20000,
                                        0, 32'h20000, 32'h20000, 0));
         pending_q.push_back(make_query(1'(m), 0, 0, 32'h10000, 0, 0, 32'h10000,
                                        32'h10000, 32'h10000));
         pending_q.push_back(make_query(1'(m), 0, 0, 32'h10000, 0, 32'h10000, 0,
                                        32'h10000, 32'h10000));
         pending_q.push_back(make_query(1'(m), 0, 0, 0, 0, 0, 0, 0, 0));
         pending_q.push_back(make_query(1'(m), 32'h80000000, 32'h80000000, 32'h7fffffff,
                                        32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                        32'h7fffffff, 32'h80000000));
         pending_q.push_back(make_query(1'(m), 32'h7fffffff, 32'h80000000, 32'h80000000,
                                        32'h7fffffff, 32'hffffffff, 32'hffffffff,
                                        32'h00000001, 32'h00000001));
         // far intersection of nearly parallel lines
         pending_q.push_back(make_query(1'(m), 0, 0, 32'h7fff0000, 1, 0, 32'h10000,
                                        32'h7fff0000, 32'h10000 - 1));
         pending_q.push_back(make_query(1'(m), 0, 0, 1, 0, 0, 1, 0, 0));
         pending_q.push_back(make_query(1'(m), 32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa,
                                        32'h55555555, 32'h0000ffff, 32'hffff0000,
                                        32'hffff0000, 32'h0000ffff));
         pending_q.push_back(make_query(1'(m), 32'h00010000, 32'h00010000, 32'h00030000,
                                        32'h00010001, 32'h00020000, 0, 32'h00020000,
                                        32'h00050000));
      end
      drain();
      calm = 1'b0;

      // random phases over register settings, extremes included
      for (int ph = 0; ph < 9; ph++) begin
         write_reg(lsi_pkg::CSR_SEGMENT_TOLERANCE, (ph < 5) ? tols[ph] : $urandom_range(32768));
         write_reg(lsi_pkg::CSR_PARALLEL_EPSILON, (ph < 5) ? epss[ph] : $urandom());
         if (ph == 3) calm = 1'b1;
         if (ph == 2) hold_pop = 1'b1;
         for (int i = 0; i < 105; i++) pending_q.push_back(rand_query());
         drain();
         calm = 1'b0;
      end

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
